@@ design/dag_critical_path_engine_macros.svh @@
// assertion macros for the critical path engine checker
`ifndef DAG_CRITICAL_PATH_ENGINE_MACROS_SVH
`define DAG_CRITICAL_PATH_ENGINE_MACROS_SVH

// same-cycle implication
`define DCP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DCP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/dcp_pkg.sv @@
// shared constants, types and helpers of the critical path engine
package dcp_pkg;

    localparam int MAX_NODES   = 1024;
    localparam int MAX_EDGES   = 16384;
    localparam int WEIGHT_BITS = 16;

    localparam int NODE_W  = $clog2(MAX_NODES);
    localparam int NCNT_W  = NODE_W + 1;
    localparam int EIDX_W  = $clog2(MAX_EDGES);
    localparam int ECNT_W  = EIDX_W + 1;
    localparam int DIST_W  = 26;
    localparam int PTR_AW  = NCNT_W + 1;
    localparam int LIST_AW = EIDX_W + 1;
    localparam int EDGE_DW = 2 * NODE_W + WEIGHT_BITS;
    localparam int NODE_DW = DIST_W + ECNT_W + 1;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_ADD     = 2'd0;
    localparam t_cmd CMD_COMPUTE = 2'd1;
    localparam t_cmd CMD_CLEAR   = 2'd2;
    localparam t_cmd CMD_SPARE   = 2'd3;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_RANGE = 2'd2;
    localparam t_status ST_DONE  = 2'd3;

    typedef struct packed {
        logic [WEIGHT_BITS-1:0] w;
        logic [NODE_W-1:0]      to;
        logic [NODE_W-1:0]      from;
    } t_edge;

    typedef struct packed {
        logic [DIST_W-1:0] dval;
        logic [ECNT_W-1:0] deg;
        logic              mark;
    } t_node;

    typedef struct packed {
        logic              go;
        logic [NCNT_W-1:0] n;
        logic [ECNT_W-1:0] held;
        logic [NODE_W-1:0] target;
    } t_dcp_req;

    typedef struct packed {
        logic              done;
        logic [DIST_W-1:0] longest;
        logic [ECNT_W-1:0] crit;
    } t_dcp_res;

    function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] a,
                                                  input logic [WEIGHT_BITS-1:0] w);
        logic [DIST_W:0] s;
        s = {1'b0, a} + (DIST_W+1)'(w);
        return s[DIST_W] ? DIST_MAX : s[DIST_W-1:0];
    endfunction

endpackage

@@ design/dcp_ram.sv @@
// generic simple dual-port ram with registered read
module dcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ design/dcp_walker.sv @@
// compute sequencer: adjacency build, kahn longest path and backward critical walk
module dcp_walker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  dcp_pkg::t_dcp_req          i_req,
    input  logic                       i_ack,
    output logic [dcp_pkg::EIDX_W-1:0] o_edge_raddr,
    input  logic [dcp_pkg::EDGE_DW-1:0] i_edge_rdata,
    output dcp_pkg::t_dcp_res          o_res
);
    import dcp_pkg::*;

    typedef enum logic [21:0] {
        S_IDLE = 22'd1 << 0,  S_CLR = 22'd1 << 1,  S_CRD = 22'd1 << 2,
        S_CED  = 22'd1 << 3,  S_CO  = 22'd1 << 4,  S_CI  = 22'd1 << 5,
        S_XRD  = 22'd1 << 6,  S_XWR = 22'd1 << 7,  S_NRD = 22'd1 << 8,
        S_NWR  = 22'd1 << 9,  S_TRD = 22'd1 << 10, S_TWR = 22'd1 << 11,
        S_QRD  = 22'd1 << 12, S_QD  = 22'd1 << 13, S_ND  = 22'd1 << 14,
        S_PS   = 22'd1 << 15, S_PE  = 22'd1 << 16, S_LP  = 22'd1 << 17,
        S_LD   = 22'd1 << 18, S_ED  = 22'd1 << 19, S_NB  = 22'd1 << 20,
        S_DONE = 22'd1 << 21
    } t_state;

    t_state r_state, n_state;
    logic r_dir, n_dir, r_fill, n_fill;
    logic [PTR_AW-1:0] r_clr, n_clr;
    logic [ECNT_W-1:0] r_k, n_k, r_acc, n_acc, r_prev, n_prev, r_i, n_i, r_end, n_end;
    logic [ECNT_W-1:0] r_held, n_held, r_crit, n_crit;
    logic [NCNT_W-1:0] r_v, n_v, r_n, n_n, r_head, n_head, r_tail, n_tail;
    logic [NODE_W-1:0] r_now, n_now, r_tg, n_tg, r_ef, n_ef, r_et, n_et;
    logic [WEIGHT_BITS-1:0] r_ew, n_ew;
    logic [DIST_W-1:0] r_dnow, n_dnow, r_long, n_long;

    logic              ptr_we;
    logic [PTR_AW-1:0] ptr_waddr, ptr_raddr;
    logic [ECNT_W-1:0] ptr_wdata, ptr_rdata, ptr_new;
    logic               lst_we;
    logic [LIST_AW-1:0] lst_waddr, lst_raddr;
    logic [EIDX_W-1:0]  lst_wdata, lst_rdata;
    logic              nd_we;
    logic [NODE_W-1:0] nd_waddr, nd_raddr;
    t_node             nd_wdata, nd_rd;
    logic [NODE_DW-1:0] nd_rdata;
    logic              q_we;
    logic [NODE_W-1:0] q_waddr, q_raddr, q_wdata, q_rdata;

    t_edge             e_rd;
    logic              live;
    logic [DIST_W-1:0] sum, ndist;
    logic [ECNT_W-1:0] ndeg;

    assign e_rd    = t_edge'(i_edge_rdata);
    assign nd_rd   = t_node'(nd_rdata);
    assign live    = ({1'b0, e_rd.from} < r_n) && ({1'b0, e_rd.to} < r_n);
    assign ptr_new = r_fill ? ptr_rdata - ECNT_W'(1) : ptr_rdata + ECNT_W'(1);
    assign sum     = sat_add(r_dir ? nd_rd.dval : r_dnow, r_ew);
    assign ndist   = (sum > nd_rd.dval) ? sum : nd_rd.dval;
    assign ndeg    = (nd_rd.deg != '0) ? nd_rd.deg - ECNT_W'(1) : '0;

    dcp_ram #(.WIDTH(ECNT_W), .DEPTH(2 ** PTR_AW)) u_ptr (
        .i_clk, .i_we(ptr_we), .i_waddr(ptr_waddr), .i_wdata(ptr_wdata),
        .i_raddr(ptr_raddr), .o_rdata(ptr_rdata)
    );
    dcp_ram #(.WIDTH(EIDX_W), .DEPTH(2 * MAX_EDGES)) u_list (
        .i_clk, .i_we(lst_we), .i_waddr(lst_waddr), .i_wdata(lst_wdata),
        .i_raddr(lst_raddr), .o_rdata(lst_rdata)
    );
    dcp_ram #(.WIDTH(NODE_DW), .DEPTH(MAX_NODES)) u_node (
        .i_clk, .i_we(nd_we), .i_waddr(nd_waddr), .i_wdata(nd_wdata),
        .i_raddr(nd_raddr), .o_rdata(nd_rdata)
    );
    dcp_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_queue (
        .i_clk, .i_we(q_we), .i_waddr(q_waddr), .i_wdata(q_wdata),
        .i_raddr(q_raddr), .o_rdata(q_rdata)
    );

    always_comb begin
        n_state = r_state; n_dir = r_dir; n_fill = r_fill; n_clr = r_clr;
        n_k = r_k; n_acc = r_acc; n_prev = r_prev; n_i = r_i; n_end = r_end;
        n_held = r_held; n_crit = r_crit; n_v = r_v; n_n = r_n;
        n_head = r_head; n_tail = r_tail; n_now = r_now; n_tg = r_tg;
        n_ef = r_ef; n_et = r_et; n_ew = r_ew; n_dnow = r_dnow; n_long = r_long;
        ptr_we = 1'b0; ptr_waddr = '0; ptr_wdata = '0; ptr_raddr = '0;
        lst_we = 1'b0; lst_waddr = '0; lst_wdata = '0; lst_raddr = '0;
        nd_we = 1'b0; nd_waddr = '0; nd_wdata = '0; nd_raddr = '0;
        q_we = 1'b0; q_waddr = '0; q_wdata = '0; q_raddr = '0;
        o_edge_raddr = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.go) begin
                    n_n = i_req.n; n_held = i_req.held; n_tg = i_req.target;
                    n_clr = '0;
                    n_state = S_CLR;
                end
            end
            S_CLR: begin
                ptr_we = 1'b1; ptr_waddr = r_clr;
                n_clr = r_clr + PTR_AW'(1);
                if (r_clr == '1) begin
                    n_k = '0; n_fill = 1'b0;
                    n_state = S_CRD;
                end
            end
            S_CRD: begin
                o_edge_raddr = r_k[EIDX_W-1:0];
                if (r_k == r_held) begin
                    n_v = '0;
                    if (!r_fill) begin
                        n_dir = 1'b0; n_acc = '0;
                        n_state = S_XRD;
                    end else begin
                        n_prev = '0; n_head = '0; n_tail = '0; n_dir = 1'b0;
                        n_state = S_NRD;
                    end
                end else begin
                    n_state = S_CED;
                end
            end
            S_CED: begin
                n_ef = e_rd.from; n_et = e_rd.to; n_ew = e_rd.w;
                ptr_raddr = {1'b0, 1'b0, e_rd.from};
                if (live) begin
                    n_state = S_CO;
                end else begin
                    n_k = r_k + ECNT_W'(1);
                    n_state = S_CRD;
                end
            end
            S_CO: begin
                ptr_we = 1'b1; ptr_waddr = {1'b0, 1'b0, r_ef}; ptr_wdata = ptr_new;
                lst_we = r_fill; lst_waddr = {1'b0, ptr_new[EIDX_W-1:0]};
                lst_wdata = r_k[EIDX_W-1:0];
                ptr_raddr = {1'b1, 1'b0, r_et};
                n_state = S_CI;
            end
            S_CI: begin
                ptr_we = 1'b1; ptr_waddr = {1'b1, 1'b0, r_et}; ptr_wdata = ptr_new;
                lst_we = r_fill; lst_waddr = {1'b1, ptr_new[EIDX_W-1:0]};
                lst_wdata = r_k[EIDX_W-1:0];
                n_k = r_k + ECNT_W'(1);
                n_state = S_CRD;
            end
            S_XRD: begin
                ptr_raddr = {r_dir, r_v};
                n_state = S_XWR;
            end
            S_XWR: begin
                ptr_we = 1'b1; ptr_waddr = {r_dir, r_v}; ptr_wdata = r_acc + ptr_rdata;
                n_acc = r_acc + ptr_rdata;
                if (r_v == r_n) begin
                    n_v = '0; n_acc = '0;
                    if (!r_dir) begin
                        n_dir = 1'b1;
                        n_state = S_XRD;
                    end else begin
                        n_k = '0; n_fill = 1'b1;
                        n_state = S_CRD;
                    end
                end else begin
                    n_v = r_v + NCNT_W'(1);
                    n_state = S_XRD;
                end
            end
            S_NRD: begin
                ptr_raddr = {1'b1, r_v + NCNT_W'(1)};
                n_state = (r_v == r_n) ? S_QRD : S_NWR;
            end
            S_NWR: begin
                n_prev = ptr_rdata;
                nd_we = 1'b1; nd_waddr = r_v[NODE_W-1:0];
                nd_wdata = '{dval: '0, deg: ptr_rdata - r_prev, mark: 1'b0};
                if (ptr_rdata == r_prev) begin
                    q_we = 1'b1; q_waddr = r_tail[NODE_W-1:0]; q_wdata = r_v[NODE_W-1:0];
                    n_tail = r_tail + NCNT_W'(1);
                end
                n_v = r_v + NCNT_W'(1);
                n_state = S_NRD;
            end
            S_TRD: begin
                nd_raddr = r_tg;
                n_state = S_TWR;
            end
            S_TWR: begin
                n_long = nd_rd.dval;
                nd_we = 1'b1; nd_waddr = r_tg;
                nd_wdata = '{dval: nd_rd.dval, deg: nd_rd.deg, mark: 1'b1};
                q_we = 1'b1; q_waddr = '0; q_wdata = r_tg;
                n_head = '0; n_tail = NCNT_W'(1); n_dir = 1'b1; n_crit = '0;
                n_state = S_QRD;
            end
            S_QRD: begin
                q_raddr = r_head[NODE_W-1:0];
                if (r_head == r_tail) begin
                    n_state = r_dir ? S_DONE : S_TRD;
                end else begin
                    n_state = S_QD;
                end
            end
            S_QD: begin
                n_now = q_rdata; nd_raddr = q_rdata;
                n_state = S_ND;
            end
            S_ND: begin
                n_dnow = nd_rd.dval;
                ptr_raddr = {r_dir, 1'b0, r_now};
                n_state = S_PS;
            end
            S_PS: begin
                n_i = ptr_rdata;
                ptr_raddr = {r_dir, {1'b0, r_now} + NCNT_W'(1)};
                n_state = S_PE;
            end
            S_PE: begin
                n_end = ptr_rdata;
                n_state = S_LP;
            end
            S_LP: begin
                lst_raddr = {r_dir, r_i[EIDX_W-1:0]};
                if (r_i == r_end) begin
                    n_head = r_head + NCNT_W'(1);
                    n_state = S_QRD;
                end else begin
                    n_state = S_LD;
                end
            end
            S_LD: begin
                o_edge_raddr = lst_rdata;
                n_state = S_ED;
            end
            S_ED: begin
                n_ef = e_rd.from; n_et = e_rd.to; n_ew = e_rd.w;
                nd_raddr = r_dir ? e_rd.from : e_rd.to;
                n_state = S_NB;
            end
            S_NB: begin
                if (!r_dir) begin
                    nd_we = 1'b1; nd_waddr = r_et;
                    nd_wdata = '{dval: ndist, deg: ndeg, mark: nd_rd.mark};
                    if (ndeg == '0 && r_tail < NCNT_W'(MAX_NODES)) begin
                        q_we = 1'b1; q_waddr = r_tail[NODE_W-1:0]; q_wdata = r_et;
                        n_tail = r_tail + NCNT_W'(1);
                    end
                end else if (sum == r_dnow) begin
                    n_crit = r_crit + ECNT_W'(1);
                    if (!nd_rd.mark && r_tail < NCNT_W'(MAX_NODES)) begin
                        nd_we = 1'b1; nd_waddr = r_ef;
                        nd_wdata = '{dval: nd_rd.dval, deg: nd_rd.deg, mark: 1'b1};
                        q_we = 1'b1; q_waddr = r_tail[NODE_W-1:0]; q_wdata = r_ef;
                        n_tail = r_tail + NCNT_W'(1);
                    end
                end
                n_i = r_i + ECNT_W'(1);
                n_state = S_LP;
            end
            S_DONE: begin
                if (i_ack) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_dir <= n_dir; r_fill <= n_fill; r_clr <= n_clr; r_k <= n_k; r_acc <= n_acc;
        r_prev <= n_prev; r_i <= n_i; r_end <= n_end; r_held <= n_held; r_crit <= n_crit;
        r_v <= n_v; r_n <= n_n; r_head <= n_head; r_tail <= n_tail; r_now <= n_now;
        r_tg <= n_tg; r_ef <= n_ef; r_et <= n_et; r_ew <= n_ew; r_dnow <= n_dnow;
        r_long <= n_long;
    end

    assign o_res = '{done: (r_state == S_DONE), longest: r_long, crit: r_crit};
endmodule

@@ design/dag_critical_path_engine.sv @@
// critical path engine top level: handshake, configuration, edge store, result register
//
// input stream: tuser carries the command, tdata the edge or target fields
// add edge, clear and unknown commands finish in the cycle they are
// accepted; one status transfer appears on the output on the next cycle
// edge loads are taken one per cycle while the output register can drain
// compute for a valid target runs in the walker and holds tready low: it
//   clears the offset table, counts the stored edges, forms prefix sums
//   per node, fills the adjacency lists, sets up the nodes, then visits
//   each dequeued node and its adjacency entries in each of the forward
//   and backward passes, all bound by the single ram ports
// a compute with an out-of-range target answers at once with a range status
// reset empties the edge store, sets node_count to 1024 and drops any result
// when the receiver stalls the result waits in the output register and no
// new input is taken until it is transferred
// node_count is written through i_cfg_we; the user must write it only while the block is idle (not enforced)
module dag_critical_path_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,  // from_node, to_node, weight, target_node
    input  logic [1:0]  i_s_axis_tuser,  // command
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,  // longest_time, critical_edges
    output logic [1:0]  o_m_axis_tuser,  // status
    input  logic        i_cfg_we,
    input  logic [10:0] i_cfg_wdata
);
    import dcp_pkg::*;

    logic [NCNT_W-1:0] r_n;
    logic [ECNT_W-1:0] r_held;
    logic              r_busy, r_ov;
    t_status           r_st, n_st;
    logic [DIST_W-1:0] r_long, n_long;
    logic [ECNT_W-1:0] r_crit, n_crit;

    logic [NODE_W-1:0]      in_from, in_to, in_tg;
    logic [WEIGHT_BITS-1:0] in_w;
    logic                   acc, slot_free, load, ack, e_we, from_bad, tg_bad;
    t_dcp_req               req;
    t_dcp_res               res;
    logic [EIDX_W-1:0]      e_raddr;
    logic [EDGE_DW-1:0]     e_rdata;

    assign in_from = i_s_axis_tdata[9:0];
    assign in_to   = i_s_axis_tdata[19:10];
    assign in_w    = i_s_axis_tdata[35:20];
    assign in_tg   = i_s_axis_tdata[45:36];

    assign slot_free       = !r_ov || i_m_axis_tready;
    assign o_s_axis_tready = !r_busy && slot_free;
    assign acc             = i_s_axis_tvalid && o_s_axis_tready;
    assign from_bad = ({1'b0, in_from} >= r_n) || ({1'b0, in_to} >= r_n);
    assign tg_bad   = {1'b0, in_tg} >= r_n;
    assign ack      = res.done && slot_free;
    assign e_we     = acc && (i_s_axis_tuser == CMD_ADD) && !from_bad
                      && (r_held < ECNT_W'(MAX_EDGES));

    assign req = '{go: acc && (i_s_axis_tuser == CMD_COMPUTE) && !tg_bad,
                   n: r_n, held: r_held, target: in_tg};

    dcp_ram #(.WIDTH(EDGE_DW), .DEPTH(MAX_EDGES)) u_edges (
        .i_clk, .i_we(e_we), .i_waddr(r_held[EIDX_W-1:0]),
        .i_wdata({in_w, in_to, in_from}), .i_raddr(e_raddr), .o_rdata(e_rdata)
    );

    dcp_walker u_walker (
        .i_clk, .i_rst_n, .i_req(req), .i_ack(ack),
        .o_edge_raddr(e_raddr), .i_edge_rdata(e_rdata), .o_res(res)
    );

    always_comb begin
        load = 1'b0; n_st = ST_OK; n_long = '0; n_crit = '0;
        if (ack) begin
            load = 1'b1; n_st = ST_DONE; n_long = res.longest; n_crit = res.crit;
        end else if (acc) begin
            case (i_s_axis_tuser)
                CMD_ADD: begin
                    load = 1'b1;
                    if (from_bad) begin
                        n_st = ST_RANGE;
                    end else if (r_held >= ECNT_W'(MAX_EDGES)) begin
                        n_st = ST_FULL;
                    end
                end
                CMD_COMPUTE: begin
                    load = tg_bad;
                    n_st = ST_RANGE;
                end
                default: load = 1'b1;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n    <= NCNT_W'(MAX_NODES);
            r_held <= '0;
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_wdata == '0) begin
                    r_n <= NCNT_W'(1);
                end else if (i_cfg_wdata > 11'(MAX_NODES)) begin
                    r_n <= NCNT_W'(MAX_NODES);
                end else begin
                    r_n <= i_cfg_wdata;
                end
            end
            if (e_we) begin
                r_held <= r_held + ECNT_W'(1);
            end else if (acc && i_s_axis_tuser == CMD_CLEAR) begin
                r_held <= '0;
            end
            if (req.go) begin
                r_busy <= 1'b1;
            end else if (ack) begin
                r_busy <= 1'b0;
            end
            if (load) begin
                r_ov <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ov <= 1'b0;
            end
        end
        if (load) begin
            r_st <= n_st; r_long <= n_long; r_crit <= n_crit;
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tuser  = r_st;
    assign o_m_axis_tdata  = {7'b0, r_crit, r_long};
endmodule

@@ design/dcp_checker.sv @@
// port-level checker for the critical path engine, bound to the top level
`include "dag_critical_path_engine_macros.svh"

module dcp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [47:0] i_s_axis_tdata,
    input logic [1:0]  i_s_axis_tuser,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [47:0] o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser,
    input logic        i_cfg_we,
    input logic [10:0] i_cfg_wdata
);
    import dcp_pkg::*;

    `DCP_ASSERT_NEXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid, "result dropped while stalled")
    `DCP_ASSERT_NEXT(a_out_stable, o_m_axis_tvalid && !i_m_axis_tready, $stable(o_m_axis_tdata), "result changed while stalled")
    `DCP_ASSERT_SAME(a_no_take_stalled, o_m_axis_tvalid && !i_m_axis_tready, !o_s_axis_tready, "input taken while result stalled")
    `DCP_ASSERT_SAME(a_status_zero, o_m_axis_tvalid && o_m_axis_tuser != ST_DONE, o_m_axis_tdata == '0, "non-result status carries data")
endmodule

bind dag_critical_path_engine dcp_checker u_dcp_checker (.*);
